>>> rtl/sts_pkg.sv
// Shared types, codes and character constants of the s-expression token scanner.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int OUT_POS_W = 16;
  localparam int OUT_DEPTH_W = 7;
  localparam int Q_DEPTH = 4;

  // token kinds
  localparam logic [2:0] KIND_OPEN   = 3'd0;
  localparam logic [2:0] KIND_CLOSE  = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_SYMBOL = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_EXTRA_CLOSE = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED    = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

  // characters
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [23:0] WORD_INF = {8'h46, 8'h4E, 8'h49};  // "INF", first char low
  localparam logic [23:0] WORD_NAN = {8'h4E, 8'h41, 8'h4E};  // "NAN"

  typedef struct packed {
    logic [2:0]             kind;
    logic [OUT_POS_W-1:0]   first_line;
    logic [OUT_POS_W-1:0]   first_column;
    logic [OUT_POS_W-1:0]   final_line;
    logic [OUT_POS_W-1:0]   final_column;
    logic [OUT_DEPTH_W-1:0] depth;
    logic [1:0]             err;
  } rec_t;

  // all records caused by one byte, in emission order: atom, paren, end
  typedef struct packed {
    logic atom_v;
    rec_t atom;
    logic paren_v;
    rec_t paren;
    logic fin_v;
    rec_t fin;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sts_queue.sv
// Short transaction queue between the scanner front and the record emitter.
`timescale 1ns / 1ps

module sts_queue import sts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t head
);

  localparam int AW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  entry_t         slots [Q_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(Q_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sts_front.sv
// Scanner front: classifies each byte, keeps position/atom/depth state and the paren stack.
`timescale 1ns / 1ps

module sts_front import sts_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int POS_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       q_push,
  output entry_t     q_entry,
  input  logic       q_full
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? POS_MAX : v + 1'b1;
  endfunction

  // scanner state
  logic                comment_mode;
  logic [POS_BITS-1:0] line_count;
  logic [POS_BITS-1:0] column_count;
  logic [POS_BITS-1:0] token_start_line;
  logic [POS_BITS-1:0] token_start_column;
  logic [POS_BITS-1:0] token_length;
  logic [23:0]         token_head_chars;
  logic [DW-1:0]       depth_count;
  logic                error_latched;

  logic                comment_mode_next;
  logic [POS_BITS-1:0] line_count_next;
  logic [POS_BITS-1:0] column_count_next;
  logic [POS_BITS-1:0] token_start_line_next;
  logic [POS_BITS-1:0] token_start_column_next;
  logic [POS_BITS-1:0] token_length_next;
  logic [23:0]         token_head_chars_next;
  logic [DW-1:0]       depth_count_next;
  logic                error_latched_next;

  // stage register toward the queue
  logic   s1_valid;
  entry_t s1_entry;
  logic   s1_from_stack;

  // byte classes
  logic is_semi, is_nl, is_open, is_close, is_space, normal;
  logic paren_byte, atom_byte, flush_byte;
  logic push_ok, pop_ok, err_now;
  logic [POS_BITS-1:0] tl, tc, tlen;
  logic [23:0]         thead;
  logic [POS_BITS:0]   endc_sum;
  logic [POS_BITS-1:0] endc;
  logic [2:0]          atom_kind;
  logic                atom_v, paren_v, fin_v, need_read;
  logic [DW-1:0]       depth_after;
  logic [DW-1:0]       top_idx;
  entry_t              entry;
  logic                accept, s1_move;
  logic [2*POS_BITS-1:0] stack_rdata;

  assign s1_move  = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_semi  = (text_byte == CH_SEMI);
    is_nl    = (text_byte == CH_NL);
    is_open  = (text_byte == CH_OPEN);
    is_close = (text_byte == CH_CLOSE);
    is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) || (text_byte == CH_VT) ||
               (text_byte == CH_FF) || (text_byte == CH_CR);
    normal     = !is_semi && !is_nl && !comment_mode;
    paren_byte = normal && (is_open || is_close);
    atom_byte  = normal && !is_open && !is_close && !is_space;
    flush_byte = is_nl || (!is_semi && comment_mode) || paren_byte || (normal && is_space);

    // atom after this byte's extension
    tl    = token_start_line;
    tc    = token_start_column;
    tlen  = token_length;
    thead = token_head_chars;
    if (atom_byte) begin
      if (token_length == '0) begin
        tl = line_count;
        tc = column_count;
      end
      if (token_length < POS_BITS'(3)) begin
        case (token_length[1:0])
          2'd0:    thead[7:0]   = text_byte;
          2'd1:    thead[15:8]  = text_byte;
          2'd2:    thead[23:16] = text_byte;
          default: thead = token_head_chars;
        endcase
      end
      tlen = sat_inc(token_length);
    end

    atom_kind = KIND_SYMBOL;
    if (tlen == POS_BITS'(3) && (thead == WORD_INF || thead == WORD_NAN)) begin
      atom_kind = KIND_NUMBER;
    end else if (is_digit(thead[7:0])) begin
      atom_kind = KIND_NUMBER;
    end else if (tlen > POS_BITS'(1) && thead[7:0] == CH_MINUS && is_digit(thead[15:8])) begin
      atom_kind = KIND_NUMBER;
    end
    endc_sum = {1'b0, tc} + {1'b0, tlen} - {{POS_BITS{1'b0}}, 1'b1};
    endc     = endc_sum[POS_BITS] ? POS_MAX : endc_sum[POS_BITS-1:0];
    atom_v   = (flush_byte || end_of_text) && (tlen != '0) && !error_latched;

    // paren handling
    push_ok = paren_byte && is_open && !error_latched && (depth_count != DW'(MAX_DEPTH));
    pop_ok  = paren_byte && is_close && !error_latched && (depth_count != '0);
    err_now = paren_byte && !error_latched && !push_ok && !pop_ok;
    paren_v = paren_byte && !error_latched;
    depth_after = push_ok ? depth_count + 1'b1 : (pop_ok ? depth_count - 1'b1 : depth_count);

    line_count_next   = is_nl ? sat_inc(line_count) : line_count;
    column_count_next = is_nl ? '0 : sat_inc(column_count);

    fin_v     = end_of_text && !error_latched && !err_now;
    need_read = fin_v && (depth_after != '0) && !push_ok;
    top_idx   = depth_after - 1'b1;

    entry.atom_v            = atom_v;
    entry.atom.kind         = atom_kind;
    entry.atom.first_line   = OUT_POS_W'(tl);
    entry.atom.first_column = OUT_POS_W'(tc);
    entry.atom.final_line   = OUT_POS_W'(line_count);
    entry.atom.final_column = OUT_POS_W'(endc);
    entry.atom.depth        = OUT_DEPTH_W'(depth_count);
    entry.atom.err          = ERR_NONE;

    entry.paren_v            = paren_v;
    entry.paren.kind         = is_open ? KIND_OPEN : KIND_CLOSE;
    entry.paren.first_line   = OUT_POS_W'(line_count);
    entry.paren.first_column = OUT_POS_W'(column_count);
    entry.paren.final_line   = OUT_POS_W'(line_count);
    entry.paren.final_column = OUT_POS_W'(column_count);
    entry.paren.depth        = OUT_DEPTH_W'(depth_after);
    if (err_now) begin
      entry.paren.err = is_open ? ERR_OVERFLOW : ERR_EXTRA_CLOSE;
    end else begin
      entry.paren.err = ERR_NONE;
    end

    // end record; an open paren on the final byte is its own innermost position
    entry.fin_v = fin_v;
    entry.fin.kind = KIND_END;
    entry.fin.depth = OUT_DEPTH_W'(depth_after);
    if (depth_after != '0) begin
      entry.fin.err          = ERR_UNCLOSED;
      entry.fin.first_line   = OUT_POS_W'(line_count);
      entry.fin.first_column = OUT_POS_W'(column_count);
    end else begin
      entry.fin.err          = ERR_NONE;
      entry.fin.first_line   = OUT_POS_W'(line_count_next);
      entry.fin.first_column = OUT_POS_W'(column_count_next);
    end
    entry.fin.final_line   = entry.fin.first_line;
    entry.fin.final_column = entry.fin.first_column;

    // next state
    comment_mode_next       = is_semi ? 1'b1 : (is_nl ? 1'b0 : comment_mode);
    token_start_line_next   = tl;
    token_start_column_next = tc;
    token_length_next       = atom_v ? '0 : tlen;
    token_head_chars_next   = atom_v ? '0 : thead;
    depth_count_next        = depth_after;
    error_latched_next      = error_latched || err_now;
    if (end_of_text) begin
      comment_mode_next       = 1'b0;
      line_count_next         = '0;
      column_count_next       = '0;
      token_start_line_next   = '0;
      token_start_column_next = '0;
      token_length_next       = '0;
      token_head_chars_next   = '0;
      depth_count_next        = '0;
      error_latched_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_mode       <= 1'b0;
      line_count         <= '0;
      column_count       <= '0;
      token_start_line   <= '0;
      token_start_column <= '0;
      token_length       <= '0;
      token_head_chars   <= '0;
      depth_count        <= '0;
      error_latched      <= 1'b0;
      s1_valid           <= 1'b0;
    end else begin
      if (accept) begin
        comment_mode       <= comment_mode_next;
        line_count         <= line_count_next;
        column_count       <= column_count_next;
        token_start_line   <= token_start_line_next;
        token_start_column <= token_start_column_next;
        token_length       <= token_length_next;
        token_head_chars   <= token_head_chars_next;
        depth_count        <= depth_count_next;
        error_latched      <= error_latched_next;
      end
      if (accept) begin
        s1_valid <= atom_v || paren_v || fin_v;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry      <= entry;
      s1_from_stack <= need_read;
    end
  end

  // open-paren position stack; read only for the end record, held while s1 waits
  sts_ram #(
    .WIDTH(2 * POS_BITS),
    .DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (accept && push_ok),
    .waddr(depth_count[AW-1:0]),
    .wdata({line_count, column_count}),
    .re   (accept && need_read),
    .raddr(top_idx[AW-1:0]),
    .rdata(stack_rdata)
  );

  always_comb begin
    q_entry = s1_entry;
    if (s1_from_stack) begin
      q_entry.fin.first_line   = OUT_POS_W'(stack_rdata[2*POS_BITS-1:POS_BITS]);
      q_entry.fin.first_column = OUT_POS_W'(stack_rdata[POS_BITS-1:0]);
      q_entry.fin.final_line   = OUT_POS_W'(stack_rdata[2*POS_BITS-1:POS_BITS]);
      q_entry.fin.final_column = OUT_POS_W'(stack_rdata[POS_BITS-1:0]);
    end
  end

  assign q_push = s1_move;

endmodule

>>> rtl/sts_back.sv
// Record emitter: splits each queued entry into records behind an output register.
`timescale 1ns / 1ps

module sts_back import sts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_nonempty,
  input  entry_t                 q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             token_kind,
  output logic [OUT_POS_W-1:0]   first_line,
  output logic [OUT_POS_W-1:0]   first_column,
  output logic [OUT_POS_W-1:0]   final_line,
  output logic [OUT_POS_W-1:0]   final_column,
  output logic [OUT_DEPTH_W-1:0] nest_depth,
  output logic [1:0]             error_code,
  output logic                   run_last
);

  logic atom_done, paren_done;
  logic take_atom, take_paren, pick_last, load;
  rec_t pick;

  always_comb begin
    take_atom  = q_head.atom_v && !atom_done;
    take_paren = !take_atom && q_head.paren_v && !paren_done;
    if (take_atom) begin
      pick      = q_head.atom;
      pick_last = !q_head.paren_v && !q_head.fin_v;
    end else if (take_paren) begin
      pick      = q_head.paren;
      pick_last = !q_head.fin_v;
    end else begin
      pick      = q_head.fin;
      pick_last = 1'b1;
    end
    load  = q_nonempty && (!out_valid || !out_stall);
    q_pop = load && pick_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_done  <= 1'b0;
      paren_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (pick_last) begin
          atom_done  <= 1'b0;
          paren_done <= 1'b0;
        end else if (take_atom) begin
          atom_done <= 1'b1;
        end else begin
          paren_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= pick.kind;
      first_line   <= pick.first_line;
      first_column <= pick.first_column;
      final_line   <= pick.final_line;
      final_column <= pick.final_column;
      nest_depth   <= pick.depth;
      error_code   <= pick.err;
      run_last     <= pick_last;
    end
  end

endmodule

>>> rtl/sexpr_token_scanner.sv
// Top level of the s-expression token scanner: front, transaction queue, record emitter.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): one source byte per transaction, with
//   end_of_text marking the last byte of a text. Output channel (out_valid /
//   out_stall): one token record per transaction, in source order; run_last
//   flags the final record caused by a byte. Bytes that cause no record
//   (atom characters, comment text, blanks) produce no output transaction.
//   A byte's records pass through the front stage, the queue and the output
//   register, in that order.
//   Throughput: one byte per cycle in while in_stall is low, and one record
//   per cycle out while out_stall is low. A byte can cause up to three records
//   (atom, paren, end record); the 4-entry queue soaks up such bursts and
//   in_stall rises only when it and the front stage are both full. A stalled
//   record stays in the output register; the next one waits in the queue.
//   The open-paren stack is a MAX_DEPTH-entry RAM; it is read only for the
//   unclosed-paren end record, when the final byte is accepted.
//   Reset (rst, synchronous) empties the queue and output register and returns
//   the scanner to the start of a text; the stack RAM is not cleared. After
//   an end_of_text byte the scanner returns to the same start state by itself.
//   After an error record nothing more is emitted for that text, not even an end record.
module sexpr_token_scanner import sts_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int POS_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             token_kind,
  output logic [OUT_POS_W-1:0]   first_line,
  output logic [OUT_POS_W-1:0]   first_column,
  output logic [OUT_POS_W-1:0]   final_line,
  output logic [OUT_POS_W-1:0]   final_column,
  output logic [OUT_DEPTH_W-1:0] nest_depth,
  output logic [1:0]             error_code,
  output logic                   run_last
);

  logic   q_push, q_full, q_pop, q_nonempty;
  entry_t q_entry, q_head;

  // classify bytes, track positions, depth and the paren stack
  sts_front #(
    .MAX_DEPTH(MAX_DEPTH),
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_full     (q_full)
  );

  // decouples the byte rate from the record rate
  sts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // one record per output transaction
  sts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .first_line  (first_line),
    .first_column(first_column),
    .final_line  (final_line),
    .final_column(final_column),
    .nest_depth  (nest_depth),
    .error_code  (error_code),
    .run_last    (run_last)
  );

  // the end record always closes the records of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> run_last)
    else $error("end record not flagged as last");

  // unclosed-paren errors only ride on end records with open parens left
  a_unclosed_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_UNCLOSED |-> token_kind == KIND_END && nest_depth != '0)
    else $error("unclosed error on wrong record");

  // extra closing paren is reported at depth zero
  a_extra_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_EXTRA_CLOSE |-> token_kind == KIND_CLOSE && nest_depth == '0)
    else $error("extra close paren record malformed");

  // a clean open paren always leaves a nonzero depth
  a_open_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_OPEN && error_code == ERR_NONE |-> nest_depth != '0)
    else $error("open paren with zero depth");

endmodule

>>> tb/sv/sts_tb_pkg.sv
// Token record type and scoreboard class for the s-expression token scanner bench.
`timescale 1ns / 1ps

package sts_tb_pkg;
  import sts_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam logic [15:0] POS_TOP = 16'hFFFF;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] first_line;
    logic [15:0] first_column;
    logic [15:0] final_line;
    logic [15:0] final_column;
    logic [6:0]  depth;
    logic [1:0]  err;
    logic        last;
  } token_rec_t;

  class token_scoreboard;
    bit          comment_on;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [23:0] tok_head;
    logic [6:0]  depth;
    logic [31:0] open_pos [STACK_DEPTH];
    bit          err_on;
    token_rec_t  due_tokens[$];
    int          mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    // start-of-text state; the paren stack keeps its contents
    function void restart();
      comment_on = 0;
      line_no = '0;
      col_no = '0;
      tok_line = '0;
      tok_col = '0;
      tok_len = '0;
      tok_head = '0;
      depth = '0;
      err_on = 0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == POS_TOP) ? v : v + 16'd1;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void emit(logic [2:0] kind, logic [15:0] fl, logic [15:0] fc,
                       logic [15:0] ll, logic [15:0] lc, logic [6:0] d, logic [1:0] e);
      token_rec_t r;
      r.kind = kind;
      r.first_line = fl;
      r.first_column = fc;
      r.final_line = ll;
      r.final_column = lc;
      r.depth = d;
      r.err = e;
      r.last = 1'b0;
      due_tokens.insert(due_tokens.size(), r);
    endfunction

    // close out the pending atom, if any
    function void end_atom();
      logic [2:0]  kind;
      logic [16:0] stop;
      if (tok_len == 0 || err_on) return;
      kind = KIND_SYMBOL;
      if (tok_len == 3 && (tok_head == WORD_INF || tok_head == WORD_NAN)) kind = KIND_NUMBER;
      else if (digit(tok_head[7:0])) kind = KIND_NUMBER;
      else if (tok_len > 1 && tok_head[7:0] == CH_MINUS && digit(tok_head[15:8]))
        kind = KIND_NUMBER;
      stop = {1'b0, tok_col} + {1'b0, tok_len} - 17'd1;
      if (stop > {1'b0, POS_TOP}) stop = {1'b0, POS_TOP};
      emit(kind, tok_line, tok_col, line_no, stop[15:0], depth, ERR_NONE);
      tok_len = '0;
      tok_head = '0;
    endfunction

    // one accepted input transaction: append the records it should produce
    function void scan_byte(logic [7:0] b, logic eot);
      int          queued;
      logic        advance;
      logic [31:0] top_pos;
      token_rec_t  r;
      queued = due_tokens.size();
      advance = 1'b1;
      if (b == CH_SEMI) begin
        comment_on = 1;
      end else if (b == CH_NL) begin
        end_atom();
        comment_on = 0;
        line_no = bump(line_no);
        col_no = '0;
        advance = 1'b0;
      end else if (comment_on) begin
        end_atom();
      end else if (b == CH_OPEN) begin
        end_atom();
        if (!err_on) begin
          if (depth >= STACK_DEPTH) begin
            emit(KIND_OPEN, line_no, col_no, line_no, col_no, depth, ERR_OVERFLOW);
            err_on = 1;
          end else begin
            open_pos[depth] = {line_no, col_no};
            depth++;
            emit(KIND_OPEN, line_no, col_no, line_no, col_no, depth, ERR_NONE);
          end
        end
      end else if (b == CH_CLOSE) begin
        end_atom();
        if (!err_on) begin
          if (depth == 0) begin
            emit(KIND_CLOSE, line_no, col_no, line_no, col_no, '0, ERR_EXTRA_CLOSE);
            err_on = 1;
          end else begin
            depth--;
            emit(KIND_CLOSE, line_no, col_no, line_no, col_no, depth, ERR_NONE);
          end
        end
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR) begin
        end_atom();
      end else begin
        if (tok_len == 0) begin
          tok_line = line_no;
          tok_col = col_no;
        end
        if (tok_len < 3) tok_head[8*tok_len +: 8] = b;
        tok_len = bump(tok_len);
      end
      if (advance) col_no = bump(col_no);

      if (eot) begin
        end_atom();
        if (!err_on) begin
          if (depth > 0) begin
            top_pos = open_pos[depth - 1];
            emit(KIND_END, top_pos[31:16], top_pos[15:0], top_pos[31:16], top_pos[15:0],
                 depth, ERR_UNCLOSED);
          end else begin
            emit(KIND_END, line_no, col_no, line_no, col_no, '0, ERR_NONE);
          end
        end
        restart();
      end

      if (due_tokens.size() > queued) begin
        r = due_tokens.pop_back();
        r.last = 1'b1;
        due_tokens.insert(due_tokens.size(), r);
      end
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(token_rec_t got);
      token_rec_t want;
      if (due_tokens.size() == 0) begin
        $error("token record with nothing expected: kind %0d", got.kind);
        mismatches++;
        return;
      end
      want = due_tokens.pop_front();
      cmp("token_kind", want.kind, got.kind);
      cmp("first_line", want.first_line, got.first_line);
      cmp("first_column", want.first_column, got.first_column);
      cmp("final_line", want.final_line, got.final_line);
      cmp("final_column", want.final_column, got.final_column);
      cmp("nest_depth", want.depth, got.depth);
      cmp("error_code", want.err, got.err);
      cmp("run_last", want.last, got.last);
    endfunction
  endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level bench for the s-expression token scanner: stimulus, back-pressure, checks.
`timescale 1ns / 1ps

module testbench;
  import sts_pkg::*;
  import sts_tb_pkg::*;

  // Guard only.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Long output hold-off: starts once this many records went through.
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 300;
  // Random texts stop once about this many bytes were sent.
  localparam int RANDOM_BYTES = 115;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;
  typedef enum {TXT_NOISE, TXT_EXTRA_CLOSE, TXT_OPEN_LEFT, TXT_BALANCED} text_shape_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  token_kind;
  logic [15:0] first_line;
  logic [15:0] first_column;
  logic [15:0] final_line;
  logic [15:0] final_column;
  logic [6:0]  nest_depth;
  logic [1:0]  error_code;
  logic        run_last;

  token_scoreboard sb;

  // sender pacing
  int   burst_left = 0;
  int   random_bytes = 0;
  logic [7:0] text_q[$];

  // receiver pacing
  int       records_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int       cycle_count = 0;

  sexpr_token_scanner u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the transaction is taken (valid high,
  // stall low at an edge). Between bursts the sender may drop valid for a
  // random gap; bursts now and then run long so there are stretches with no gaps.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.scan_byte(b, eot);
  endtask

  // Send the assembled text; its last byte carries end_of_text.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void put_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_digits();
    repeat ($urandom_range(1, 4)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // One atom. Mix of number forms, near misses of INF / NAN, a lone minus,
  // non-ASCII bytes and plain symbol characters.
  function automatic void put_atom();
    logic [7:0] c;
    case ($urandom_range(0, 8))
      0: put_str("INF");
      1: put_str("NAN");
      2: begin
        if ($urandom_range(0, 1)) put_str("IN");
        else put_str("NANO");
      end
      3: put_byte(CH_MINUS);
      4: begin
        put_byte(CH_MINUS);
        put_digits();
      end
      5: put_digits();
      6: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(128, 255)));
      default: begin
        repeat ($urandom_range(1, 5)) begin
          do c = 8'($urandom_range(33, 126));
          while (c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI);
          put_byte(c);
        end
      end
    endcase
  endfunction

  // Whitespace of every flavor, or a comment that may hold parens.
  function automatic void put_gap();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: put_byte(CH_TAB);
      1: put_byte(CH_VT);
      2: put_byte(CH_FF);
      3: put_byte(CH_CR);
      4: put_byte(CH_NL);
      5: begin
        put_byte(CH_SEMI);
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_NL);
          put_byte(c);
        end
        // sometimes no newline closes the comment, so it runs on into what follows
        if ($urandom_range(0, 3) != 0) put_byte(CH_NL);
      end
      default: put_byte(CH_SPACE);
    endcase
  endfunction

  // Mostly well-formed nested lists with random content; the rest are texts
  // with a stray close paren, texts left open, and raw byte noise.
  function automatic void put_random_text();
    int          r;
    int          lvl;
    text_shape_e shape;
    r = $urandom_range(0, 9);
    shape = (r < 3) ? text_shape_e'(r) : TXT_BALANCED;
    if (shape == TXT_NOISE) begin
      repeat ($urandom_range(4, 14)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    lvl = 0;
    repeat ($urandom_range(4, 14)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          put_byte(CH_OPEN);
          lvl++;
        end
        2: begin
          if (lvl > 0) begin
            put_byte(CH_CLOSE);
            lvl--;
          end else begin
            put_atom();
          end
        end
        3: put_gap();
        default: begin
          put_atom();
          if ($urandom_range(0, 1)) put_gap();
        end
      endcase
    end
    if (shape == TXT_OPEN_LEFT) lvl = $urandom_range(0, lvl);
    else if (lvl == 0 && $urandom_range(0, 1)) put_atom();  // atom flushed by end of text
    if (shape != TXT_OPEN_LEFT) repeat (lvl) put_byte(CH_CLOSE);
    if (shape == TXT_EXTRA_CLOSE) begin
      put_byte(CH_CLOSE);
      put_atom();  // ignored once the error has latched
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: check every taken record, then pick the next stall value.
  // The stall pattern switches between random modes (free, light, heavy,
  // toggle); once, early in the random part, stall is held high so the queue
  // fills and the block pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    token_rec_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = token_kind;
      got.first_line = first_line;
      got.first_column = first_column;
      got.final_line = final_line;
      got.final_column = final_column;
      got.depth = nest_depth;
      got.err = error_code;
      got.last = run_last;
      sb.check_record(got);
      records_seen++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && records_seen >= HOLD_AFTER) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed texts.
    // Every token kind, INF and NAN, minus-digit, a lone minus with a high
    // byte, tab and vertical tab, a comment holding parens (the paren in the
    // comment flushes NAN), a newline, and three records from the last byte.
    put_str("(INF");
    put_byte(CH_TAB);
    put_str("-9");
    put_byte(CH_VT);
    put_str("NAN;()");
    put_byte(CH_NL);
    put_byte(CH_MINUS);
    put_byte(8'hFF);
    put_byte(CH_CLOSE);
    send_text();
    // Extra close paren latches the error; the final byte then yields nothing.
    put_str(")x");
    send_text();
    // Unclosed paren: end record points at the inner paren. Form feed, space, CR.
    put_byte(CH_OPEN);
    put_byte(CH_FF);
    put_str("( ");
    put_byte(CH_CR);
    send_text();
    // Atom on the final byte, flushed ahead of the end record.
    put_str("5");
    send_text();

    // Random texts.
    while (random_bytes < RANDOM_BYTES) begin
      put_random_text();
      random_bytes += text_q.size();
      send_text();
    end

    // Depth overflow on the open paren past the stack; the trailing close is dropped.
    repeat (STACK_DEPTH + 1) put_byte(CH_OPEN);
    put_byte(CH_CLOSE);
    send_text();
    // Full stack left open: the end record gives the deepest open paren, the final byte itself.
    repeat (STACK_DEPTH) put_byte(CH_OPEN);
    send_text();

    // Drain, then wait for anything unexpected to show up.
    in_valid <= 1'b0;
    end_of_text <= 1'b0;
    while (sb.due_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sts_queue.sv
rtl/sts_front.sv
rtl/sts_back.sv
rtl/sexpr_token_scanner.sv
tb/sv/sts_tb_pkg.sv
tb/sv/testbench.sv
